[rtl/core/vrsh_pkg.sv]
// Shared codes and default sizes for the register, stack and heap unit.
package vrsh_pkg;

    // Default storage sizes
    localparam int DEF_HEAP_BYTES  = 65536;
    localparam int DEF_STACK_DEPTH = 256;

    // The heap is split into byte-wide banks, one per byte lane of a word
    localparam int HEAP_BANKS  = 8;
    localparam int BANK_SEL_W  = 3;

    // Action codes
    localparam logic [2:0] ACT_REG_READ   = 3'd0;
    localparam logic [2:0] ACT_REG_WRITE  = 3'd1;
    localparam logic [2:0] ACT_PUSH       = 3'd2;
    localparam logic [2:0] ACT_POP        = 3'd3;
    localparam logic [2:0] ACT_HEAP_READ  = 3'd4;
    localparam logic [2:0] ACT_HEAP_WRITE = 3'd5;

    // Register select of the stack index; lower codes are the general registers
    localparam logic [2:0] REG_S = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_REG   = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_SEGFAULT  = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd5;

endpackage

[rtl/core/vm_register_stack_heap_unit.sv]
// Top level of the register, stack and heap state unit of a small virtual machine.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid / in_stall    | action, reg_select, heap_address,
//          |           |                        | access_size, write_value
//  out     | output    | out_valid / out_stall  | read_data, status
//  cfg     | input     | cfg_we                 | cfg_wdata (heap_limit)
//
// A word is accepted in the idle state and checked in the next cycle. Register
// operations, push and heap write (and every error) finish at the check; pop and
// heap read finish in a data state after it, waiting on the registered read of the
// stack RAM and of the eight byte-wide heap banks.
// A new word is taken while a finished result waits in the output register;
// the check cycle holds while that result is stalled.
// Reset clears the registers, the stack index and the heap limit; the stack
// and heap memories are not cleared, so no clearing pass follows reset.
module vm_register_stack_heap_unit
    import vrsh_pkg::*;
#(
    parameter int HEAP_BYTES  = DEF_HEAP_BYTES,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [2:0]  reg_select,
    input  logic [15:0] heap_address,
    input  logic [3:0]  access_size,
    input  logic [63:0] write_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] read_data,
    output logic [2:0]  status
);

    localparam int STACK_AW  = $clog2(STACK_DEPTH);
    localparam int HEAP_ROWS = (HEAP_BYTES + HEAP_BANKS - 1) / HEAP_BANKS;
    localparam int ROW_W     = $clog2(HEAP_ROWS);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DATA  = 3'b100
    } state_t;

    state_t      state_reg, state_next;

    logic [16:0] heap_limit_reg;
    logic [63:0] gp_reg [5];
    logic [63:0] s_reg, s_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] read_data_reg;
    logic [2:0]  status_reg;

    // Latched input word
    logic [2:0]  act_reg;
    logic [2:0]  sel_reg;
    logic [15:0] addr_reg;
    logic [3:0]  size_reg;
    logic [63:0] val_reg;

    logic        in_accept;
    logic        out_free;
    logic        commit;
    logic [2:0]  chk_status;
    logic [63:0] chk_data;
    logic        chk_needs_read;
    logic [63:0] reg_value;
    logic [16:0] heap_end;
    logic        size_ok;

    logic        load_out;
    logic [63:0] load_data;
    logic [2:0]  load_status;

    logic        rf_we;
    logic [63:0] rf_wdata;

    logic        stack_we, stack_re;
    logic [63:0] stack_rdata;
    logic [63:0] s_minus1;

    logic [BANK_SEL_W-1:0] byte_off;
    logic [13:0]           row_plus;
    logic [ROW_W-1:0]      row_base, row_next;
    logic                  heap_re;
    logic                  heap_we    [HEAP_BANKS];
    logic [ROW_W-1:0]      heap_row   [HEAP_BANKS];
    logic [7:0]            heap_wdata [HEAP_BANKS];
    logic [7:0]            heap_rdata [HEAP_BANKS];
    logic [63:0]           heap_word;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == S_ISSUE) && out_free;

    assign s_minus1  = s_reg - 64'd1;
    assign reg_value = (sel_reg < REG_S) ? gp_reg[sel_reg] : s_reg;

    // Heap bounds and size checks
    assign heap_end = {1'b0, addr_reg} + {13'd0, size_reg};
    assign size_ok  = (size_reg == 4'd1) || (size_reg == 4'd2) ||
                      (size_reg == 4'd4) || (size_reg == 4'd8);

    // Checks on the latched word against the current state.
    always_comb
    begin
        chk_status     = ST_OK;
        chk_data       = 64'd0;
        chk_needs_read = 1'b0;
        unique case (act_reg) inside
            ACT_REG_READ:
            begin
                if (sel_reg > REG_S)
                begin
                    chk_status = ST_BAD_REG;
                end
                else
                begin
                    chk_data = reg_value;
                end
            end
            ACT_REG_WRITE:
            begin
                if (sel_reg > REG_S)
                begin
                    chk_status = ST_BAD_REG;
                end
            end
            ACT_PUSH:
            begin
                if (s_reg >= 64'(STACK_DEPTH))
                begin
                    chk_status = ST_OVERFLOW;
                end
            end
            ACT_POP:
            begin
                if (sel_reg > REG_S)
                begin
                    chk_status = ST_BAD_REG;
                end
                else if (s_reg == 64'd0)
                begin
                    chk_status = ST_UNDERFLOW;
                end
                else if (s_reg > 64'(STACK_DEPTH))
                begin
                    chk_status = ST_OVERFLOW;
                end
                else
                begin
                    chk_needs_read = 1'b1;
                end
            end
            ACT_HEAP_READ, ACT_HEAP_WRITE:
            begin
                if ((heap_end > heap_limit_reg) || (32'(heap_end) > 32'(HEAP_BYTES)))
                begin
                    chk_status = ST_SEGFAULT;
                end
                else if (!size_ok)
                begin
                    chk_status = ST_BAD_SIZE;
                end
                else if (act_reg == ACT_HEAP_READ)
                begin
                    chk_needs_read = 1'b1;
                end
            end
            default:
            begin
                chk_status = ST_OK;
            end
        endcase
    end

    // Memory side effects of a committed word.
    assign stack_we = commit && (act_reg == ACT_PUSH) && (chk_status == ST_OK);
    assign stack_re = commit && (act_reg == ACT_POP) && chk_needs_read;
    assign heap_re  = commit && (act_reg == ACT_HEAP_READ) && chk_needs_read;

    // Register file write: register write at commit, pop when the word returns.
    always_comb
    begin
        rf_we    = 1'b0;
        rf_wdata = val_reg;
        if (commit && (act_reg == ACT_REG_WRITE) && (chk_status == ST_OK))
        begin
            rf_we = 1'b1;
        end
        else if (state_reg == S_DATA && act_reg == ACT_POP)
        begin
            rf_we    = 1'b1;
            rf_wdata = stack_rdata;
        end
    end

    // Stack index update; a pop into s overrides the decrement.
    always_comb
    begin
        s_next = s_reg;
        if (stack_we)
        begin
            s_next = s_reg + 64'd1;
        end
        else if (state_reg == S_DATA && act_reg == ACT_POP)
        begin
            s_next = s_minus1;
        end
        if (rf_we && sel_reg == REG_S)
        begin
            s_next = rf_wdata;
        end
    end

    // Heap bank addressing: banks below the start lane use the next row.
    assign byte_off = addr_reg[BANK_SEL_W-1:0];
    assign row_plus = {1'b0, addr_reg[15:BANK_SEL_W]} + 14'd1;
    assign row_base = ROW_W'({1'b0, addr_reg[15:BANK_SEL_W]});
    assign row_next = ROW_W'(row_plus);

    always_comb
    begin
        for (int j = 0; j < HEAP_BANKS; j++)
        begin
            logic [BANK_SEL_W-1:0] lane;
            lane          = BANK_SEL_W'(j) - byte_off;
            heap_row[j]   = (BANK_SEL_W'(j) >= byte_off) ? row_base : row_next;
            heap_wdata[j] = 8'(val_reg >> {lane, 3'b000});
            heap_we[j]    = commit && (act_reg == ACT_HEAP_WRITE) &&
                            (chk_status == ST_OK) && ({1'b0, lane} < size_reg);
        end
    end

    // Gather read bytes back into lane order, zero above the access size.
    always_comb
    begin
        for (int k = 0; k < HEAP_BANKS; k++)
        begin
            logic [BANK_SEL_W-1:0] bank;
            bank = byte_off + BANK_SEL_W'(k);
            heap_word[8*k +: 8] = (4'(k) < size_reg) ? heap_rdata[bank] : 8'd0;
        end
    end

    // Result loading into the output register.
    always_comb
    begin
        load_out    = 1'b0;
        load_data   = 64'd0;
        load_status = ST_OK;
        if (commit && !chk_needs_read)
        begin
            load_out    = 1'b1;
            load_data   = chk_data;
            load_status = chk_status;
        end
        else if (state_reg == S_DATA)
        begin
            load_out  = 1'b1;
            load_data = (act_reg == ACT_HEAP_READ) ? heap_word : 64'd0;
        end
    end

    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (commit)
                begin
                    state_next = chk_needs_read ? S_DATA : S_IDLE;
                end
            end
            S_DATA:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            heap_limit_reg <= 17'd0;
            s_reg          <= 64'd0;
            for (int i = 0; i < 5; i++)
            begin
                gp_reg[i] <= 64'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            s_reg         <= s_next;
            if (cfg_we)
            begin
                heap_limit_reg <= cfg_wdata;
            end
            for (int i = 0; i < 5; i++)
            begin
                if (rf_we && sel_reg == 3'(i))
                begin
                    gp_reg[i] <= rf_wdata;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= action;
            sel_reg  <= reg_select;
            addr_reg <= heap_address;
            size_reg <= access_size;
            val_reg  <= write_value;
        end
        if (load_out)
        begin
            read_data_reg <= load_data;
            status_reg    <= load_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    // Stack memory: push writes at s, pop reads at s - 1.
    vrsh_ram #(
        .WIDTH (64),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (s_reg[STACK_AW-1:0]),
        .wdata (val_reg),
        .re    (stack_re),
        .raddr (s_minus1[STACK_AW-1:0]),
        .rdata (stack_rdata)
    );

    // Heap memory: one byte-wide bank per byte lane.
    for (genvar j = 0; j < HEAP_BANKS; j++)
    begin : g_heap_bank
        vrsh_ram #(
            .WIDTH (8),
            .DEPTH (HEAP_ROWS)
        ) u_heap_ram (
            .clk   (clk),
            .we    (heap_we[j]),
            .waddr (heap_row[j]),
            .wdata (heap_wdata[j]),
            .re    (heap_re),
            .raddr (heap_row[j]),
            .rdata (heap_rdata[j])
        );
    end

    // An accepted word is always checked in the next cycle.
    a_accept_to_issue: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_ISSUE)
        else $error("accepted word did not move to the check cycle");

    // Returning memory data must find the output register empty.
    a_data_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DATA |-> !out_valid_reg)
        else $error("read data returned while a result still waits");

    // A new result only appears after a check or a data cycle.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_ISSUE || $past(state_reg) == S_DATA)
        else $error("result appeared without a committed word");

    // A successful push advances the stack index by one.
    a_push_index: assert property (@(posedge clk) disable iff (!rst_n)
        stack_we |=> s_reg == $past(s_reg) + 64'd1)
        else $error("push did not advance the stack index");

    // Heap banks 0 and 7 are never written outside a committed heap write.
    a_heap_write_gate: assert property (@(posedge clk) disable iff (!rst_n)
        heap_we[0] || heap_we[7] |-> commit && act_reg == ACT_HEAP_WRITE)
        else $error("heap bank written outside a heap write");

endmodule

[rtl/core/vrsh_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module vrsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
